[hdl/rrts_pkg.sv]
package rrts_pkg;

   // Request operation codes.
   typedef enum logic [2:0] {
      OP_LAUNCH     = 3'd0,
      OP_TICK       = 3'd1,
      OP_READY_ADD  = 3'd2,
      OP_READY_REM  = 3'd3,
      OP_BLOCK_ADD  = 3'd4,
      OP_BLOCK_REM  = 3'd5
   } op_type;

   // Task states, as carried on new_state and current_state.
   localparam logic [1:0] ST_READY     = 2'd0;
   localparam logic [1:0] ST_RUNNING   = 2'd1;
   localparam logic [1:0] ST_BLOCKED   = 2'd2;
   localparam logic [1:0] ST_SUSPENDED = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_WEIGHTED = 1'b0;
   localparam logic CSR_RELOAD   = 1'b1;

   // List selectors.
   localparam logic LIST_READY   = 1'b0;
   localparam logic LIST_BLOCKED = 1'b1;

endpackage

[hdl/round_robin_task_scheduler.sv]
// Round robin task scheduler with a ready list and a blocked list, both held as singly linked
// lists over the task slots in one on-chip table (link, state and quota for each slot), with
// slot 0 as the idle task. Each request transfer (launch, tick, ready add or remove, blocked
// add or remove) produces exactly one response transfer giving the running task, its state,
// whether a remove found its task, and whether the ready list is empty. Requests are handled
// one at a time by a sequencer that reads, modifies and writes back the slot table through a
// registered read port and a separate write port. A list walk visits each slot in two steps,
// a read (S_WALK) and a compare (S_WSTEP). A weighted tick that keeps its task only spends a
// tick of quota; a tick that requeues the running task walks both lists, then pops the ready
// head. A launch walks both lists; in weighted mode it also reloads every quota, which makes
// it the longest request. The sequencer goes back to idle before it takes the next request,
// and a stalled response holds it until the output register is free. After reset a clearing
// pass writes every slot of the table, and no request is taken until it is done. The response
// sits in an output register, so the next request can be taken while it waits. Configuration
// writes are always taken and must only be made while the block is idle.
module round_robin_task_scheduler
   import rrts_pkg::*;
#(
   parameter int TASK_SLOTS = 8,
   parameter int QUOTA_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_operation,
   input  logic [2:0] req_task_slot,
   input  logic [1:0] req_new_state,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_current_task,
   output logic [1:0] rsp_current_state,
   output logic       rsp_found,
   output logic       rsp_ready_empty,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   // Slot address width, and link width (a link also holds the null value TASK_SLOTS).
   localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int LW = $clog2(TASK_SLOTS + 1);
   localparam logic [LW-1:0] NIL = LW'(TASK_SLOTS);

   typedef struct packed {
      logic [LW-1:0]         link;
      logic [1:0]            status;
      logic [QUOTA_BITS-1:0] quota;
   } slot_word_type;

   typedef enum logic [16:0] {
      S_CLEAR  = 17'h00001,
      S_IDLE   = 17'h00002,
      S_WALK   = 17'h00004,
      S_WSTEP  = 17'h00008,
      S_UNLW   = 17'h00010,
      S_APPW1  = 17'h00020,
      S_APPW2  = 17'h00040,
      S_LAUNCH = 17'h00080,
      S_SWEEP  = 17'h00100,
      S_TICK   = 17'h00200,
      S_TICKD  = 17'h00400,
      S_POPCHK = 17'h00800,
      S_POPD   = 17'h01000,
      S_FALLBK = 17'h02000,
      S_FBD    = 17'h04000,
      S_OUT    = 17'h08000,
      S_OUTD   = 17'h10000
   } state_type;

   function automatic logic [QUOTA_BITS-1:0] dec_sat(input logic [QUOTA_BITS-1:0] q);
      dec_sat = (q == '0) ? '0 : q - 1'b1;
   endfunction

   // Slot table.
   slot_word_type mem [TASK_SLOTS];
   slot_word_type rd_word_ff;
   logic [SW-1:0] rd_addr;
   logic          wr_en, wr_link_en, wr_stat_en, wr_quota_en;
   logic [SW-1:0] wr_addr;
   slot_word_type wr_word;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (wr_link_en) begin
            mem[wr_addr].link <= wr_word.link;
         end
         if (wr_stat_en) begin
            mem[wr_addr].status <= wr_word.status;
         end
         if (wr_quota_en) begin
            mem[wr_addr].quota <= wr_word.quota;
         end
      end
      rd_word_ff <= mem[rd_addr];
   end

   // Control and working registers.
   state_type       state_ff, state_in;
   op_type          op_ff, op_in;
   logic [SW-1:0]   slot_ff, slot_in;
   logic [1:0]      nst_ff, nst_in;
   logic            list_ff, list_in;
   logic [LW-1:0]   cur_ff, cur_in;
   logic [LW-1:0]   prev_ff, prev_in;
   logic [LW-1:0]   cnt_ff, cnt_in;
   logic            found_ff, found_in;
   logic [LW-1:0]   rhead_ff, rhead_in, rtail_ff, rtail_in;
   logic [LW-1:0]   bhead_ff, bhead_in, btail_ff, btail_in;
   logic [SW-1:0]   running_ff, running_in;
   logic            weighted_ff, weighted_in;
   logic [7:0]      reload_ff, reload_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      rsp_task_ff, rsp_task_in;
   logic [1:0]      rsp_state_ff, rsp_state_in;
   logic            rsp_found_ff, rsp_found_in;
   logic            rsp_empty_ff, rsp_empty_in;

   // Helpers.
   logic [QUOTA_BITS-1:0] reload_q;
   logic [LW-1:0]         sel_tail, app_head, app_tail;
   logic                  app_list;
   logic [1:0]            app_status;
   logic                  is_remove;
   logic                  unl_done;
   logic                  run_ok;

   assign reload_q   = QUOTA_BITS'(reload_ff);
   assign sel_tail   = (list_ff == LIST_BLOCKED) ? btail_ff : rtail_ff;
   assign app_list   = (op_ff == OP_BLOCK_ADD) ? LIST_BLOCKED : LIST_READY;
   assign app_head   = (app_list == LIST_BLOCKED) ? bhead_ff : rhead_ff;
   assign app_tail   = (app_list == LIST_BLOCKED) ? btail_ff : rtail_ff;
   assign app_status = (op_ff == OP_BLOCK_ADD) ? ST_BLOCKED : ST_READY;
   assign is_remove  = (op_ff == OP_READY_REM) || (op_ff == OP_BLOCK_REM);
   assign run_ok     = (running_ff != '0) && (rd_word_ff.status == ST_RUNNING);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      slot_in      = slot_ff;
      nst_in       = nst_ff;
      list_in      = list_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      rhead_in     = rhead_ff;
      rtail_in     = rtail_ff;
      bhead_in     = bhead_ff;
      btail_in     = btail_ff;
      running_in   = running_ff;
      weighted_in  = weighted_ff;
      reload_in    = reload_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_task_in  = rsp_task_ff;
      rsp_state_in = rsp_state_ff;
      rsp_found_in = rsp_found_ff;
      rsp_empty_in = rsp_empty_ff;
      rd_addr      = running_ff;
      wr_en        = 1'b0;
      wr_link_en   = 1'b0;
      wr_stat_en   = 1'b0;
      wr_quota_en  = 1'b0;
      wr_addr      = slot_ff;
      wr_word      = '{link: NIL, status: ST_READY, quota: '0};
      unl_done     = 1'b0;

      // The response register is freed by its transfer.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            CSR_WEIGHTED: weighted_in = csr_wdata[0];
            CSR_RELOAD:   reload_in   = csr_wdata;
            default:      ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en       = 1'b1;
            wr_link_en  = 1'b1;
            wr_stat_en  = 1'b1;
            wr_quota_en = 1'b1;
            wr_addr     = cnt_ff[SW-1:0];
            if (cnt_ff == LW'(TASK_SLOTS - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = op_type'(req_operation);
               slot_in  = SW'(req_task_slot);
               nst_in   = req_new_state;
               found_in = 1'b0;
               prev_in  = NIL;
               cnt_in   = '0;
               list_in  = LIST_READY;
               cur_in   = rhead_ff;
               unique case (op_type'(req_operation))
                  OP_LAUNCH: begin
                     slot_in  = SW'(1);
                     state_in = S_WALK;
                  end
                  OP_TICK: state_in = S_TICK;
                  OP_READY_ADD, OP_READY_REM, OP_BLOCK_ADD: begin
                     state_in = (32'(req_task_slot) < TASK_SLOTS) ? S_WALK : S_OUT;
                  end
                  OP_BLOCK_REM: begin
                     list_in  = LIST_BLOCKED;
                     cur_in   = bhead_ff;
                     state_in = (32'(req_task_slot) < TASK_SLOTS) ? S_WALK : S_OUT;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_WALK: begin
            rd_addr = cur_ff[SW-1:0];
            if (cur_ff == NIL || cnt_ff == LW'(TASK_SLOTS)) begin
               unl_done = 1'b1;
            end else begin
               state_in = S_WSTEP;
            end
         end
         S_WSTEP: begin
            if (cur_ff == LW'(slot_ff)) begin
               // Found: bridge the predecessor (or the head) over this slot.
               if (prev_ff == NIL) begin
                  if (list_ff == LIST_BLOCKED) begin
                     bhead_in = rd_word_ff.link;
                  end else begin
                     rhead_in = rd_word_ff.link;
                  end
               end else begin
                  wr_en        = 1'b1;
                  wr_link_en   = 1'b1;
                  wr_addr      = prev_ff[SW-1:0];
                  wr_word.link = rd_word_ff.link;
               end
               if (sel_tail == LW'(slot_ff)) begin
                  if (list_ff == LIST_BLOCKED) begin
                     btail_in = prev_ff;
                  end else begin
                     rtail_in = prev_ff;
                  end
               end
               state_in = S_UNLW;
            end else begin
               prev_in  = cur_ff;
               cur_in   = rd_word_ff.link;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_WALK;
            end
         end
         S_UNLW: begin
            wr_en      = 1'b1;
            wr_link_en = 1'b1;
            wr_addr    = slot_ff;
            if (is_remove) begin
               wr_stat_en     = 1'b1;
               wr_word.status = nst_ff;
               found_in       = 1'b1;
            end
            unl_done = 1'b1;
         end
         S_APPW1: begin
            wr_en          = 1'b1;
            wr_link_en     = 1'b1;
            wr_stat_en     = 1'b1;
            wr_addr        = slot_ff;
            wr_word.status = app_status;
            if (op_ff == OP_TICK && weighted_ff) begin
               wr_quota_en   = 1'b1;
               wr_word.quota = reload_q;
            end
            if (app_head == NIL || app_tail == NIL) begin
               if (app_list == LIST_BLOCKED) begin
                  bhead_in = LW'(slot_ff);
                  btail_in = LW'(slot_ff);
               end else begin
                  rhead_in = LW'(slot_ff);
                  rtail_in = LW'(slot_ff);
               end
               state_in = (op_ff == OP_TICK) ? S_POPCHK : S_OUT;
            end else begin
               state_in = S_APPW2;
            end
         end
         S_APPW2: begin
            wr_en        = 1'b1;
            wr_link_en   = 1'b1;
            wr_addr      = app_tail[SW-1:0];
            wr_word.link = LW'(slot_ff);
            if (app_list == LIST_BLOCKED) begin
               btail_in = LW'(slot_ff);
            end else begin
               rtail_in = LW'(slot_ff);
            end
            state_in = (op_ff == OP_TICK) ? S_POPCHK : S_OUT;
         end
         S_LAUNCH: begin
            wr_en          = 1'b1;
            wr_stat_en     = 1'b1;
            wr_addr        = slot_ff;
            wr_word.status = ST_RUNNING;
            running_in     = slot_ff;
            cnt_in         = '0;
            state_in       = weighted_ff ? S_SWEEP : S_OUT;
         end
         S_SWEEP: begin
            // Every quota is reloaded; the launched task has already spent one tick.
            wr_en         = 1'b1;
            wr_quota_en   = 1'b1;
            wr_addr       = cnt_ff[SW-1:0];
            wr_word.quota = (cnt_ff == LW'(1)) ? dec_sat(reload_q) : reload_q;
            if (cnt_ff == LW'(TASK_SLOTS - 1)) begin
               state_in = S_OUT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_TICK: state_in = S_TICKD;
         S_TICKD: begin
            prev_in = NIL;
            cnt_in  = '0;
            list_in = LIST_READY;
            cur_in  = rhead_ff;
            wr_addr = running_ff;
            if (weighted_ff && rhead_ff == NIL) begin
               state_in = S_FALLBK;
            end else if (weighted_ff && run_ok && rd_word_ff.quota != '0) begin
               // The running task keeps the processor and spends a tick of quota.
               wr_en         = 1'b1;
               wr_quota_en   = 1'b1;
               wr_word.quota = rd_word_ff.quota - 1'b1;
               state_in      = S_OUT;
            end else if (run_ok) begin
               slot_in  = running_ff;
               state_in = S_WALK;
            end else if (running_ff == '0) begin
               wr_en          = 1'b1;
               wr_stat_en     = 1'b1;
               wr_word.status = ST_READY;
               state_in       = S_POPCHK;
            end else begin
               state_in = S_POPCHK;
            end
         end
         S_POPCHK: begin
            rd_addr = rhead_ff[SW-1:0];
            state_in = (rhead_ff == NIL) ? S_FALLBK : S_POPD;
         end
         S_POPD: begin
            wr_en      = 1'b1;
            wr_link_en = 1'b1;
            wr_addr    = rhead_ff[SW-1:0];
            if (rhead_ff[SW-1:0] != '0 && rd_word_ff.status == ST_READY) begin
               wr_stat_en     = 1'b1;
               wr_word.status = ST_RUNNING;
               if (weighted_ff) begin
                  wr_quota_en   = 1'b1;
                  wr_word.quota = dec_sat(rd_word_ff.quota);
               end
            end
            running_in = rhead_ff[SW-1:0];
            if (rd_word_ff.link == NIL) begin
               rhead_in = NIL;
               rtail_in = NIL;
            end else begin
               rhead_in = rd_word_ff.link;
            end
            state_in = S_FALLBK;
         end
         S_FALLBK: begin
            state_in = (rhead_ff == NIL) ? S_FBD : S_OUT;
         end
         S_FBD: begin
            // Nothing runnable: drop back to the idle task if the running task is blocked or is the idle task.
            if (rd_word_ff.status == ST_BLOCKED || running_ff == '0) begin
               running_in     = '0;
               wr_en          = 1'b1;
               wr_stat_en     = 1'b1;
               wr_addr        = '0;
               wr_word.status = ST_RUNNING;
            end
            state_in = S_OUT;
         end
         S_OUT: state_in = S_OUTD;
         S_OUTD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_task_in  = 3'(running_ff);
               rsp_state_in = rd_word_ff.status;
               rsp_found_in = found_ff;
               rsp_empty_in = (rhead_ff == NIL);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // End of a list walk: decide what the request does next.
      if (unl_done) begin
         prev_in = NIL;
         cnt_in  = '0;
         if (is_remove) begin
            state_in = S_OUT;
         end else if (list_ff == LIST_READY) begin
            list_in  = LIST_BLOCKED;
            cur_in   = bhead_ff;
            state_in = S_WALK;
         end else if (op_ff == OP_LAUNCH) begin
            state_in = S_LAUNCH;
         end else begin
            state_in = S_APPW1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         rhead_ff     <= NIL;
         rtail_ff     <= NIL;
         bhead_ff     <= NIL;
         btail_ff     <= NIL;
         running_ff   <= '0;
         weighted_ff  <= 1'b0;
         reload_ff    <= 8'd1;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rhead_ff     <= rhead_in;
         rtail_ff     <= rtail_in;
         bhead_ff     <= bhead_in;
         btail_ff     <= btail_in;
         running_ff   <= running_in;
         weighted_ff  <= weighted_in;
         reload_ff    <= reload_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
      op_ff        <= op_in;
      slot_ff      <= slot_in;
      nst_ff       <= nst_in;
      list_ff      <= list_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      rsp_task_ff  <= rsp_task_in;
      rsp_state_ff <= rsp_state_in;
      rsp_found_ff <= rsp_found_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_task  = rsp_task_ff;
   assign rsp_current_state = rsp_state_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_ready_empty   = rsp_empty_ff;
   assign csr_ready         = 1'b1;

endmodule

[verif/tb_top.sv]
module tb_top
   import rrts_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 8;
   localparam logic [3:0] NIL = 4'd8;
   localparam int STALL_LIMIT = 20000;

   // Operation codes that the package leaves unnamed; the block must ignore them.
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_operation;
   logic [2:0] req_task_slot;
   logic [1:0] req_new_state;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [2:0] rsp_current_task;
   logic [1:0] rsp_current_state;
   logic       rsp_found;
   logic       rsp_ready_empty;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_index;
   logic [7:0] csr_wdata;

   round_robin_task_scheduler u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_task_slot(req_task_slot),
      .req_new_state(req_new_state),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_current_task(rsp_current_task), .rsp_current_state(rsp_current_state),
      .rsp_found(rsp_found), .rsp_ready_empty(rsp_ready_empty),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   typedef struct packed {
      logic [2:0] task_id;
      logic [1:0] state;
      logic       found;
      logic       ready_empty;
   } sched_view_type;

   // Shadow of the scheduler: configuration, slot table and list pointers.
   logic       sh_weighted;
   logic [7:0] sh_reload;
   logic [3:0] sh_link [SLOTS];
   logic [1:0] sh_status [SLOTS];
   logic [7:0] sh_quota [SLOTS];
   logic [3:0] rdy_head, rdy_tail, blk_head, blk_tail;
   logic [2:0] sh_running;

   sched_view_type pending_views[$];
   int             error_count;
   int             idle_cycles;
   bit             hold_off;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Unlinks a slot from one list; returns whether the slot was there.
   function automatic bit list_detach(input logic [3:0] slot, ref logic [3:0] head,
                                      ref logic [3:0] tail);
      logic [3:0] prev;
      logic [3:0] cur;
      prev = NIL;
      cur = head;
      for (int n = 0; n < SLOTS; n++) begin
         if (cur >= NIL) break;
         if (cur == slot) begin
            if (prev >= NIL) head = sh_link[cur];
            else sh_link[prev] = sh_link[cur];
            if (tail == slot) tail = prev;
            sh_link[slot] = NIL;
            return 1'b1;
         end
         prev = cur;
         cur = sh_link[cur];
      end
      return 1'b0;
   endfunction

   function automatic void list_join(input logic [3:0] slot, ref logic [3:0] head,
                                     ref logic [3:0] tail);
      sh_link[slot] = NIL;
      if (head >= NIL || tail >= NIL) head = slot;
      else sh_link[tail] = slot;
      tail = slot;
   endfunction

   function automatic void move_to_list(input logic [3:0] slot, input bit blocked);
      void'(list_detach(slot, rdy_head, rdy_tail));
      void'(list_detach(slot, blk_head, blk_tail));
      if (blocked) begin
         list_join(slot, blk_head, blk_tail);
         sh_status[slot] = ST_BLOCKED;
      end else begin
         list_join(slot, rdy_head, rdy_tail);
         sh_status[slot] = ST_READY;
      end
   endfunction

   function automatic logic [2:0] take_ready_head();
      logic [3:0] t;
      t = rdy_head;
      rdy_head = sh_link[t];
      if (rdy_head >= NIL) begin
         rdy_head = NIL;
         rdy_tail = NIL;
      end
      sh_link[t] = NIL;
      return t[2:0];
   endfunction

   function automatic void fall_back_to_idle();
      if (rdy_head >= NIL && (sh_status[sh_running] == ST_BLOCKED || sh_running == 3'd0)) begin
         sh_running = 3'd0;
         sh_status[0] = ST_RUNNING;
      end
   endfunction

   function automatic void shadow_reset();
      sh_weighted = 1'b0;
      sh_reload = 8'd1;
      for (int i = 0; i < SLOTS; i++) begin
         sh_link[i] = NIL;
         sh_status[i] = ST_READY;
         sh_quota[i] = 8'd0;
      end
      rdy_head = NIL; rdy_tail = NIL; blk_head = NIL; blk_tail = NIL;
      sh_running = 3'd0;
   endfunction

   // Applies one request to the shadow and returns the view the block should report.
   function automatic sched_view_type schedule_step(input logic [2:0] op,
                                                    input logic [2:0] slot,
                                                    input logic [1:0] nst);
      sched_view_type v;
      logic [2:0]     cur;
      logic [2:0]     t;
      v.found = 1'b0;
      case (op)
         OP_LAUNCH: begin
            void'(list_detach(4'd1, rdy_head, rdy_tail));
            void'(list_detach(4'd1, blk_head, blk_tail));
            sh_running = 3'd1;
            sh_status[1] = ST_RUNNING;
            if (sh_weighted) begin
               for (int i = 0; i < SLOTS; i++) sh_quota[i] = sh_reload;
               if (sh_quota[1] != 0) sh_quota[1]--;
            end
         end
         OP_TICK: begin
            cur = sh_running;
            if (!sh_weighted) begin
               if (cur != 0 && sh_status[cur] == ST_RUNNING) move_to_list({1'b0, cur}, 1'b0);
               else if (cur == 0) sh_status[0] = ST_READY;
               if (rdy_head < NIL) begin
                  t = take_ready_head();
                  sh_running = t;
                  if (t != 0 && sh_status[t] == ST_READY) sh_status[t] = ST_RUNNING;
               end
               fall_back_to_idle();
            end else if (rdy_head < NIL && cur != 0 && sh_status[cur] == ST_RUNNING &&
                         sh_quota[cur] != 0) begin
               // A task with quota left keeps the processor and no fallback applies.
               sh_quota[cur]--;
            end else begin
               if (rdy_head < NIL) begin
                  if (cur != 0 && sh_status[cur] == ST_RUNNING) begin
                     sh_quota[cur] = sh_reload;
                     move_to_list({1'b0, cur}, 1'b0);
                  end else if (cur == 0) begin
                     sh_status[0] = ST_READY;
                  end
                  t = take_ready_head();
                  sh_running = t;
                  if (t != 0 && sh_status[t] == ST_READY) begin
                     sh_status[t] = ST_RUNNING;
                     if (sh_quota[t] != 0) sh_quota[t]--;
                  end
               end
               fall_back_to_idle();
            end
         end
         OP_READY_ADD: move_to_list({1'b0, slot}, 1'b0);
         OP_BLOCK_ADD: move_to_list({1'b0, slot}, 1'b1);
         OP_READY_REM: if (list_detach({1'b0, slot}, rdy_head, rdy_tail)) begin
            sh_status[slot] = nst;
            v.found = 1'b1;
         end
         OP_BLOCK_REM: if (list_detach({1'b0, slot}, blk_head, blk_tail)) begin
            sh_status[slot] = nst;
            v.found = 1'b1;
         end
         default: ;
      endcase
      v.task_id = sh_running;
      v.state = sh_status[sh_running];
      v.ready_empty = (rdy_head >= NIL);
      return v;
   endfunction

   // Response checker: every response transfer is matched with the oldest prediction.
   always @(posedge clock) begin
      sched_view_type exp_v;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_views.size() == 0) begin
            $error("response with nothing expected: task %0d", rsp_current_task);
            error_count++;
         end else begin
            exp_v = pending_views.pop_front();
            if (rsp_current_task !== exp_v.task_id) begin
               $error("current_task expected %0d actual %0d", exp_v.task_id, rsp_current_task);
               error_count++;
            end
            if (rsp_current_state !== exp_v.state) begin
               $error("current_state expected %0d actual %0d", exp_v.state, rsp_current_state);
               error_count++;
            end
            if (rsp_found !== exp_v.found) begin
               $error("found expected %0d actual %0d", exp_v.found, rsp_found);
               error_count++;
            end
            if (rsp_ready_empty !== exp_v.ready_empty) begin
               $error("ready_empty expected %0d actual %0d", exp_v.ready_empty,
                      rsp_ready_empty);
               error_count++;
            end
         end
      end
   end

   // The receiver stalls on its own pattern: quiet, light and heavy spells and, when asked, one
   // long hold-off so that the block fills its output register and stalls its input.
   initial begin
      int mode;
      int span;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(10, 80);
         repeat (span) begin
            @(negedge clock);
            if (hold_off) rsp_stall <= 1'b1;
            else if (mode == 0) rsp_stall <= 1'b0;
            else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
            else rsp_stall <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // Watchdog: counts cycles in which no transfer takes place on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [2:0] op, input logic [2:0] slot,
                               input logic [1:0] nst);
      req_valid <= 1'b1;
      req_operation <= op;
      req_task_slot <= slot;
      req_new_state <= nst;
      do @(posedge clock); while (req_stall);
      pending_views.push_back(schedule_step(op, slot, nst));
      @(negedge clock);
   endtask

   task automatic pause_sender();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clock);
   endtask

   // Each write waits past the falling edge on which its strobe drops, so back to back writes never
   // schedule two updates of the strobe in the same time step.
   task automatic write_register(input logic idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_WEIGHTED) sh_weighted = value[0];
      else sh_reload = value;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Configuration is only changed once every response is in and the sequencer has settled.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_views.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   // A random item: mostly well-formed traffic among the slots, with some unused codes.
   task automatic random_item();
      int pick;
      logic [2:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 3) op = OP_LAUNCH;
      else if (pick < 35) op = OP_TICK;
      else if (pick < 55) op = OP_READY_ADD;
      else if (pick < 70) op = OP_READY_REM;
      else if (pick < 83) op = OP_BLOCK_ADD;
      else if (pick < 96) op = OP_BLOCK_REM;
      else op = ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;
      send_request(op, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
   endtask

   typedef struct {
      logic [2:0]     op;
      logic [2:0]     slot;
      logic [1:0]     nst;
      bit             typed;
      sched_view_type view;
   } directed_row_type;

   // Directed table; typed rows carry results that follow straight from reset.
   directed_row_type directed_rows[] = '{
      '{OP_TICK,      3'd0, ST_READY,     1'b1, '{3'd0, ST_RUNNING, 1'b0, 1'b1}},
      '{OP_READY_REM, 3'd3, ST_BLOCKED,   1'b1, '{3'd0, ST_RUNNING, 1'b0, 1'b1}},
      '{OP_BLOCK_REM, 3'd7, ST_SUSPENDED, 1'b1, '{3'd0, ST_RUNNING, 1'b0, 1'b1}},
      '{OP_SPARE_A,   3'd7, ST_SUSPENDED, 1'b1, '{3'd0, ST_RUNNING, 1'b0, 1'b1}},
      '{OP_READY_ADD, 3'd7, ST_READY,     1'b1, '{3'd0, ST_RUNNING, 1'b0, 1'b0}},
      '{OP_READY_ADD, 3'd2, ST_READY,     1'b0, '0},
      '{OP_READY_ADD, 3'd3, ST_READY,     1'b0, '0},
      '{OP_READY_ADD, 3'd4, ST_READY,     1'b0, '0},
      '{OP_READY_REM, 3'd2, ST_SUSPENDED, 1'b0, '0},
      '{OP_READY_REM, 3'd7, ST_READY,     1'b0, '0},
      '{OP_READY_REM, 3'd4, ST_BLOCKED,   1'b0, '0},
      '{OP_READY_REM, 3'd4, ST_BLOCKED,   1'b0, '0},
      '{OP_BLOCK_ADD, 3'd5, ST_READY,     1'b0, '0},
      '{OP_BLOCK_ADD, 3'd6, ST_READY,     1'b0, '0},
      '{OP_READY_ADD, 3'd5, ST_READY,     1'b0, '0},
      '{OP_BLOCK_REM, 3'd6, ST_RUNNING,   1'b0, '0},
      '{OP_LAUNCH,    3'd0, ST_READY,     1'b0, '0},
      '{OP_TICK,      3'd0, ST_READY,     1'b0, '0},
      '{OP_BLOCK_ADD, 3'd0, ST_READY,     1'b0, '0},
      '{OP_TICK,      3'd0, ST_READY,     1'b0, '0},
      '{OP_TICK,      3'd0, ST_READY,     1'b0, '0},
      '{OP_SPARE_B,   3'd1, ST_BLOCKED,   1'b0, '0},
      '{OP_TICK,      3'd0, ST_READY,     1'b0, '0}
   };

   initial begin
      sched_view_type predicted;
      error_count = 0;
      hold_off = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_TICK;
      req_task_slot = 3'd0;
      req_new_state = ST_READY;
      csr_valid = 1'b0;
      csr_index = CSR_WEIGHTED;
      csr_wdata = 8'd0;
      shadow_reset();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part in plain mode straight after reset.
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].op, directed_rows[i].slot, directed_rows[i].nst);
         predicted = pending_views[$];
         if (directed_rows[i].typed && predicted !== directed_rows[i].view) begin
            $error("directed row %0d: shadow disagrees with its typed result", i);
            error_count++;
         end
         if ($urandom_range(0, 2) == 0) pause_sender();
      end

      // Random phases across settings, the register extremes among them.
      for (int phase = 0; phase < 7; phase++) begin
         drain_and_settle();
         case (phase)
            0: begin write_register(CSR_WEIGHTED, 8'd1); write_register(CSR_RELOAD, 8'd0); end
            1: write_register(CSR_RELOAD, 8'd2);
            2: write_register(CSR_RELOAD, 8'd255);
            3: begin write_register(CSR_WEIGHTED, 8'd0); write_register(CSR_RELOAD, 8'hAA); end
            4: begin write_register(CSR_WEIGHTED, 8'hFE); write_register(CSR_RELOAD, 8'h55); end
            5: write_register(CSR_RELOAD, 8'd3);
            default: write_register(CSR_WEIGHTED, 8'd0);
         endcase
         // Phases start with a launch so weighted quotas take the new reload value.
         send_request(OP_LAUNCH, 3'd0, ST_READY);
         if (phase == 2) begin
            fork
               begin
                  hold_off = 1'b1;
                  repeat (300) @(negedge clock);
                  hold_off = 1'b0;
               end
            join_none
         end
         for (int n = 0; n < 245; ) begin
            int burst;
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && n < 245; b++, n++) random_item();
            if ($urandom_range(0, 3) != 0) pause_sender();
         end
      end

      req_valid <= 1'b0;
      while (pending_views.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
